>>> design/assert_macros.svh
// Assertion macros used by the checker file of the string matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/kmp_pkg.sv
// Types and constants shared by the streaming KMP matcher modules.
package kmp_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAT_NEW,
    KIND_PAT_ADD,
    KIND_TEXT_NEW,
    KIND_TEXT_ADD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic status;
    logic found;
    logic match_end;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FALL
  } state_t;

endpackage

>>> design/kmp_front.sv
// Input stage: accepts stream transactions and classifies each byte.
module kmp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]          s_axis_tuser,   // [0] command, [1] first
  output logic                push_valid,
  input  logic                push_ready,
  output kmp_pkg::item_t      push_item
);

  logic           held;
  kmp_pkg::item_t item;
  kmp_pkg::kind_t kind;
  logic           accept;

  always_comb begin
    unique case (s_axis_tuser[0])
      kmp_pkg::CMD_PATTERN: kind = s_axis_tuser[1] ? kmp_pkg::KIND_PAT_NEW
                                                   : kmp_pkg::KIND_PAT_ADD;
      kmp_pkg::CMD_TEXT:    kind = s_axis_tuser[1] ? kmp_pkg::KIND_TEXT_NEW
                                                   : kmp_pkg::KIND_TEXT_ADD;
      default:              kind = kmp_pkg::KIND_TEXT_ADD;
    endcase
  end

  assign s_axis_tready = !held || push_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_valid    = held;
  assign push_item     = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.kind       <= kind;
      item.byte_value <= s_axis_tdata;
    end
  end

endmodule

>>> design/kmp_queue.sv
// Short queue of classified bytes between the input stage and the engine.
module kmp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  kmp_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output kmp_pkg::item_t out_item
);

  localparam int QD = kmp_pkg::QUEUE_DEPTH;
  localparam int QW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  kmp_pkg::item_t entries [QD];
  logic [QW-1:0]  wptr;
  logic [QW-1:0]  rptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign in_ready  = count != CW'(QD);
  assign out_valid = count != '0;
  assign out_item  = entries[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QW'(QD - 1)) ? '0 : wptr + QW'(1);
      end
      if (pop) begin
        rptr <= (rptr == QW'(QD - 1)) ? '0 : rptr + QW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= in_item;
    end
  end

endmodule

>>> design/kmp_back.sv
// Match engine: pattern store, prefix table, fallback sequencer and result register.
module kmp_back #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_pop,
  input  kmp_pkg::item_t   q_item,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output kmp_pkg::result_t result
);

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam logic [LW-1:0] PLEN_FULL = LW'(MAX_PATTERN);

  kmp_pkg::state_t  state;
  kmp_pkg::state_t  state_next;

  logic [LW-1:0]    plen;
  logic [AW-1:0]    pre_len;
  logic [LW-1:0]    match_idx;
  logic             found;
  logic             overflow;
  logic             out_valid;

  logic [AW-1:0]    idx;
  logic [7:0]       cur_byte;
  logic             cur_text;
  kmp_pkg::result_t res;

  logic [7:0]       pat_mem [MAX_PATTERN];
  logic [AW-1:0]    lps_mem [MAX_PATTERN];
  logic [7:0]       pat_q;
  logic [AW-1:0]    lps_q;

  logic             is_text;
  logic             is_new;
  logic             is_new_pat;
  logic [LW-1:0]    eff_plen;
  logic [AW-1:0]    eff_pre;
  logic [LW-1:0]    eff_midx;
  logic             eff_found;
  logic             eff_ovf;
  logic             full;
  logic             need_loop;
  logic [AW-1:0]    start_idx;
  kmp_pkg::result_t imm_res;

  logic             out_free;
  logic             take;
  logic             fall;
  logic             finish;
  logic             eq;
  logic [LW-1:0]    kn;
  logic             hit;
  kmp_pkg::result_t fin_res;

  logic             pat_we;
  logic [AW-1:0]    pat_waddr;
  logic             pat_re;
  logic [AW-1:0]    pat_raddr;
  logic             lps_we;
  logic [AW-1:0]    lps_waddr;
  logic [AW-1:0]    lps_wdata;

  // Decode of the byte at the head of the queue, with new-pattern and
  // new-text clearing applied first.
  always_comb begin
    is_text    = (q_item.kind == kmp_pkg::KIND_TEXT_NEW) ||
                 (q_item.kind == kmp_pkg::KIND_TEXT_ADD);
    is_new_pat = q_item.kind == kmp_pkg::KIND_PAT_NEW;
    is_new     = is_new_pat || (q_item.kind == kmp_pkg::KIND_TEXT_NEW);
    eff_plen   = is_new_pat ? '0 : plen;
    eff_pre    = is_new_pat ? '0 : pre_len;
    eff_midx   = is_new ? '0 : match_idx;
    eff_found  = is_new ? 1'b0 : found;
    eff_ovf    = is_new_pat ? 1'b0 : overflow;
    full       = eff_plen == PLEN_FULL;
    imm_res    = '0;
    if (is_text) begin
      need_loop = !eff_ovf && !eff_found && (eff_plen != '0);
      start_idx = (eff_midx >= eff_plen) ? '0 : eff_midx[AW-1:0];
      imm_res.status = eff_ovf;
      if (eff_ovf || eff_found) begin
        imm_res.found = eff_found;
      end else begin
        imm_res.found     = 1'b1;
        imm_res.match_end = 1'b1;
      end
    end else begin
      need_loop      = !full && (eff_plen != '0);
      start_idx      = eff_pre;
      imm_res.status = full || eff_ovf;
      imm_res.found  = eff_found;
    end
  end

  assign out_free = !out_valid || m_axis_tready;
  assign eq       = pat_q == cur_byte;
  assign kn       = LW'(idx) + LW'(eq);
  assign hit      = kn == plen;

  always_comb begin
    fin_res        = '0;
    fin_res.status = overflow;
    if (cur_text) begin
      fin_res.found     = found || hit;
      fin_res.match_end = hit;
    end else begin
      fin_res.found = found;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kmp_pkg::ST_IDLE: if (take && need_loop) state_next = kmp_pkg::ST_READ;
      kmp_pkg::ST_READ: state_next = kmp_pkg::ST_CMP;
      kmp_pkg::ST_CMP:  state_next = fall ? kmp_pkg::ST_FALL : kmp_pkg::ST_IDLE;
      kmp_pkg::ST_FALL: state_next = kmp_pkg::ST_CMP;
      default:          state_next = kmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    take   = 1'b0;
    fall   = 1'b0;
    finish = 1'b0;
    pat_re = 1'b0;
    unique case (state)
      kmp_pkg::ST_IDLE: take = q_valid && out_free;
      kmp_pkg::ST_READ: pat_re = 1'b1;
      kmp_pkg::ST_CMP: begin
        fall   = !eq && (idx != '0);
        finish = !fall;
      end
      kmp_pkg::ST_FALL: pat_re = 1'b1;
      default: ;
    endcase
  end

  assign q_pop     = take;
  assign pat_raddr = (state == kmp_pkg::ST_FALL) ? lps_q : idx;
  assign pat_we    = take && !is_text && !full;
  assign pat_waddr = eff_plen[AW-1:0];

  always_comb begin
    lps_we    = 1'b0;
    lps_waddr = plen[AW-1:0];
    lps_wdata = kn[AW-1:0];
    if (take && !is_text && !full && (eff_plen == '0)) begin
      lps_we    = 1'b1;
      lps_waddr = '0;
      lps_wdata = '0;
    end else if (finish && !cur_text) begin
      lps_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kmp_pkg::ST_IDLE;
      plen      <= '0;
      pre_len   <= '0;
      match_idx <= '0;
      found     <= 1'b0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        pre_len   <= eff_pre;
        match_idx <= eff_midx;
        if (!is_text && full) begin
          overflow <= 1'b1;
        end else begin
          overflow <= eff_ovf;
        end
        if (!is_text && !full && (eff_plen == '0)) begin
          plen <= LW'(1);
        end else begin
          plen <= eff_plen;
        end
        if (is_text && !need_loop && !eff_ovf && !eff_found) begin
          found <= 1'b1;
        end else begin
          found <= eff_found;
        end
      end else if (finish) begin
        if (cur_text) begin
          match_idx <= kn;
          if (hit) begin
            found <= 1'b1;
          end
        end else begin
          pre_len <= kn[AW-1:0];
          plen    <= plen + LW'(1);
        end
      end
      if ((take && !need_loop) || finish) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      idx      <= start_idx;
      cur_byte <= q_item.byte_value;
      cur_text <= is_text;
    end else if (state == kmp_pkg::ST_FALL) begin
      idx <= lps_q;
    end
    if (take && !need_loop) begin
      res <= imm_res;
    end else if (finish) begin
      res <= fin_res;
    end
  end

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= q_item.byte_value;
    end
    if (pat_re) begin
      pat_q <= pat_mem[pat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (lps_we) begin
      lps_mem[lps_waddr] <= lps_wdata;
    end
    if (fall) begin
      lps_q <= lps_mem[idx - AW'(1)];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign result        = res;

endmodule

>>> design/kmp_stream_matcher.sv
// Top level of the streaming KMP matcher: input stage, queue and match engine.
//
//   channel   direction  tdata                      tuser
//   s_axis    in         [7:0] byte_value           [0] command, [1] first
//   m_axis    out        [0] match_end, [1] found,  none
//                        [2] status, [7:3] zero
//
// One result transaction leaves for every input transaction, in order.
// A first pattern byte, an overflowing pattern byte, and a text byte against an empty pattern
// or after the search has stopped are answered straight from the decode; other bytes pass
// through the read and compare states, then a fallback and a compare state per prefix-table step.
// Reset is synchronous and clears lengths, flags and the queue; the stores are not cleared.
// A held input stage and a two-entry queue keep taking bytes while the engine works or a
// result waits on m_axis_tready.
module kmp_stream_matcher #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0] s_axis_tuser,   // [0] command, [1] first
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] match_end, [1] found, [2] status, [7:3] zero
);

  logic             push_valid;
  logic             push_ready;
  kmp_pkg::item_t   push_item;
  logic             q_valid;
  logic             q_pop;
  kmp_pkg::item_t   q_item;
  kmp_pkg::result_t result;

  kmp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  kmp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_item   (push_item),
    .out_valid (q_valid),
    .out_ready (q_pop),
    .out_item  (q_item)
  );

  kmp_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .result        (result)
  );

  assign m_axis_tdata = {5'b0, result};

endmodule

>>> design/kmp_checker.sv
// Port-level checker for the streaming KMP matcher and its bind statement.
`include "assert_macros.svh"

module kmp_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !m_axis_tvalid, "result valid right after reset")
  `ASSERT_CLK(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `ASSERT_CLK(a_match_found, clk, rst, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1], "match end without found")
  `ASSERT_CLK(a_overflow_no_match, clk, rst, m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[0], "match reported with overflow")

endmodule

bind kmp_stream_matcher kmp_checker u_kmp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
